// ===== sv/setq_pkg.sv =====
// ----------------------------------------------------------------------------
// setq_pkg
// Shared types and constants of the sorted expiry timer queue.
// ----------------------------------------------------------------------------
package setq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int HANDLE_W = 16;
   localparam int TIME_W   = 32;
   localparam int KIND_W   = 3;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_ADJUST = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_EXPIRED = 3'd0,
      KIND_DONE    = 3'd1,
      KIND_FULL    = 3'd2,
      KIND_ABSENT  = 3'd3,
      KIND_NONE    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_INS_RD,
      ST_INS_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INS_WR,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   expiry;
   } entry_type;

endpackage

// ===== sv/setq_ram.sv =====
// ----------------------------------------------------------------------------
// setq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module setq_ram
   import setq_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  entry_type         wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output entry_type         rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sorted_expiry_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue_top
// Timer list sorted by expiry with add, adjust, delete and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_ (op, handle, expire_time, now_time) with a
//   valid/ready transfer. Results leave on rsp_ (kind, out_handle, last).
//   Add, adjust and delete give one result each; a tick gives one expired
//   result per popped timer (up to CAPACITY), last set on the final one,
//   or a single "none" result when nothing is due.
//   Entries live in one RAM with one read port and registered read data;
//   the controller walks it one entry per step.
//   An add walks to the insert position, shifts the entries behind it
//   up and writes the new one; delete walks to the handle then compacts;
//   adjust is a delete followed by an add. A tick tests the head and
//   compacts once per popped timer; each expired result is held until
//   the next head test shows whether it is the last one. One request
//   is handled at a time; a new request is taken while the previous
//   result still waits. Reset clears the state, the entry count and the
//   result valid; entries are never read beyond the count. A stalled rsp_
//   receiver holds the result register and a tick walk with the next timer due.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue_top
   import setq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic [TIME_W-1:0]   req_expire_time,
   input  logic [TIME_W-1:0]   req_now_time,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [HANDLE_W-1:0] rsp_out_handle,
   output logic                rsp_last
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;     // walk pointer
   logic [CNT_W-1:0]    pos_ff, pos_in;     // insert position
   logic [CNT_W-1:0]    pops_ff, pops_in;
   op_type              op_ff, op_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [TIME_W-1:0]   exp_ff, exp_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic                tick_mode_ff, tick_mode_in; // compaction belongs to a tick
   kind_type            res_kind_ff, res_kind_in;     // final result, staged
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in; // also the held expired one
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [HANDLE_W-1:0] out_handle_ff, out_handle_in;
   logic                last_ff, last_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   entry_type           wr_data, rd_data;

   setq_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      pops_ff       <= pops_in;
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      exp_ff        <= exp_in;
      now_ff        <= now_in;
      tick_mode_ff  <= tick_mode_in;
      res_kind_ff   <= res_kind_in;
      res_handle_ff <= res_handle_in;
      kind_ff       <= kind_in;
      out_handle_ff <= out_handle_in;
      last_ff       <= last_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      pops_in       = pops_ff;
      op_in         = op_ff;
      handle_in     = handle_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      tick_mode_in  = tick_mode_ff;
      res_kind_in   = res_kind_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff;
      kind_in       = kind_ff;
      out_handle_in = out_handle_ff;
      last_in       = last_ff;
      req_ready     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = rd_data;
      rd_addr       = idx_ff[IDX_W-1:0];

      // drop the result register once the receiver takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = op_type'(req_op);
               handle_in = req_handle;
               exp_in    = req_expire_time;
               now_in    = req_now_time;
               idx_in    = '0;
               pops_in   = '0;
               case (op_type'(req_op))
                  OP_ADD: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_kind_in   = KIND_FULL;
                        res_handle_in = req_handle;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_INS_RD;
                     end
                  end
                  OP_ADJUST, OP_DELETE: state_in = ST_FIND_RD;
                  OP_TICK:              state_in = ST_TICK_RD;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end

         // search for the first entry holding the handle
         ST_FIND_RD: begin
            if (idx_ff >= count_ff) begin
               res_kind_in   = KIND_ABSENT;
               res_handle_in = handle_ff;
               state_in      = ST_RESP;
            end else begin
               state_in = ST_FIND_CHK;
            end
         end
         ST_FIND_CHK: begin
            if (rd_data.handle == handle_ff) begin
               tick_mode_in = 1'b0;
               state_in     = ST_DEL_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FIND_RD;
            end
         end

         // compact: entry[idx] <= entry[idx+1]
         ST_DEL_RD: begin
            if (idx_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               idx_in   = '0;
               if (tick_mode_ff) begin
                  state_in = ST_TICK_RD;
               end else if (op_ff == OP_ADJUST) begin
                  state_in = ST_INS_RD;
               end else begin
                  res_kind_in   = KIND_DONE;
                  res_handle_in = handle_ff;
                  state_in      = ST_RESP;
               end
            end else begin
               rd_addr  = IDX_W'(idx_ff + 1'b1);
               state_in = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_DEL_RD;
         end

         // find the insert position: first entry with expiry > new
         ST_INS_RD: begin
            if (idx_ff >= count_ff) begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_INS_CHK;
            end
         end
         ST_INS_CHK: begin
            if (rd_data.expiry > exp_ff) begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = ST_SHIFT_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_INS_RD;
            end
         end

         // open a gap: entry[idx] <= entry[idx-1], walking down to pos
         ST_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = ST_INS_WR;
            end else begin
               rd_addr  = IDX_W'(idx_ff - 1'b1);
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_INS_WR: begin
            wr_en          = 1'b1;
            wr_addr        = pos_ff[IDX_W-1:0];
            wr_data.handle = handle_ff;
            wr_data.expiry = exp_ff;
            count_in       = count_ff + 1'b1;
            res_kind_in    = KIND_DONE;
            res_handle_in  = handle_ff;
            state_in       = ST_RESP;
         end

         // tick: test the head, hold the popped handle, then compact
         ST_TICK_RD: begin
            rd_addr = '0;
            if (count_ff == '0 || pops_ff == CNT_W'(CAPACITY)) begin
               // nothing more can pop: the held timer, if any, is the last
               res_kind_in = (pops_ff == '0) ? KIND_NONE : KIND_EXPIRED;
               if (pops_ff == '0) begin
                  res_handle_in = '0;
               end
               state_in = ST_RESP;
            end else begin
               state_in = ST_TICK_CHK;
            end
         end
         ST_TICK_CHK: begin
            if (rd_data.expiry <= now_ff) begin
               if (pops_ff != '0 && rsp_valid_ff && !rsp_ready) begin
                  state_in = ST_TICK_CHK;   // hold until the previous result leaves
               end else begin
                  // another one is due, so the held timer is not the last
                  if (pops_ff != '0) begin
                     rsp_valid_in  = 1'b1;
                     kind_in       = KIND_EXPIRED;
                     out_handle_in = res_handle_ff;
                     last_in       = 1'b0;
                  end
                  res_handle_in = rd_data.handle;
                  pops_in       = pops_ff + 1'b1;
                  tick_mode_in  = 1'b1;
                  idx_in        = '0;
                  state_in      = ST_DEL_RD;
               end
            end else begin
               res_kind_in = (pops_ff == '0) ? KIND_NONE : KIND_EXPIRED;
               if (pops_ff == '0) begin
                  res_handle_in = '0;
               end
               state_in = ST_RESP;
            end
         end

         // load the final result once the result register is free
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               kind_in       = res_kind_ff;
               out_handle_in = res_handle_ff;
               last_in       = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_handle = out_handle_ff;
   assign rsp_last       = last_ff;

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_out_handle) && $stable(rsp_last))
      else $error("result changed while waiting");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_last_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_EXPIRED) |-> rsp_last)
      else $error("single result without last");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken during a walk");

endmodule
